FILE: design/pal_pkg.sv
// Package for the positional array list: operation, status and state codes,
// field widths and the control bundle sent down the row of entry cells.
// No dependencies.
`default_nettype none
package pal_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int VAL_W         = 32;
    localparam int POS_W         = 7;
    localparam int IDX_W         = 7;
    localparam int OP_W          = 2;
    localparam int ST_W          = 2;
    localparam int S_DATA_W      = 48;
    localparam int M_DATA_W      = 16;

    localparam logic [IDX_W-1:0] NONE_INDEX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_FIND   = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    typedef struct packed {
        logic             ins;
        logic             ers;
        logic             fnd;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: design/pal_cell.sv
// One entry cell of the list row: holds a value, shifts with its neighbours
// on insert and erase, and registers a match flag on find. Uses pal_pkg.
`default_nettype none
module pal_cell #(
    parameter int DEPTH = pal_pkg::DEFAULT_DEPTH,
    parameter int INDEX = 0
) (
    input  wire                          i_clk,
    input  wire pal_pkg::t_cell_ctl      i_ctl,
    input  wire [pal_pkg::VAL_W-1:0]     i_value,
    input  wire [pal_pkg::VAL_W-1:0]     i_left,
    input  wire [pal_pkg::VAL_W-1:0]     i_right,
    input  wire [$clog2(DEPTH+1)-1:0]    i_count,
    output logic [pal_pkg::VAL_W-1:0]    o_entry,
    output logic                         o_match
);
    import pal_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > POS_W) ? CW : POS_W;

    logic [EW-1:0]    w_pos;
    logic [EW-1:0]    w_idx;
    logic [EW-1:0]    w_cnt;
    logic [VAL_W-1:0] r_entry;
    logic             r_match;

    assign w_pos = EW'(i_ctl.pos);
    assign w_idx = EW'(INDEX);
    assign w_cnt = EW'(i_count);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && (w_idx == w_pos)) begin
            r_entry <= i_value;
        end else if (i_ctl.ins && (w_idx > w_pos)) begin
            r_entry <= i_left;
        end else if (i_ctl.ers && (w_idx >= w_pos)) begin
            r_entry <= i_right;
        end
        if (i_ctl.fnd) begin
            r_match <= (w_idx < w_cnt) && (r_entry == i_value);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule
`default_nettype wire

FILE: design/pal_find_tree.sv
// Registered priority tree over the cell match flags: yields the lowest
// matching index after one register stage per level. Uses pal_pkg.
`default_nettype none
module pal_find_tree #(
    parameter int LV = 6
) (
    input  wire                 i_clk,
    input  wire [(1<<LV)-1:0]   i_match,
    output logic                o_hit,
    output logic [LV-1:0]       o_idx
);
    import pal_pkg::*;

    localparam int NP = 1 << LV;

    logic          r_hit [1:NP-1];
    logic [LV-1:0] r_idx [1:NP-1];

    for (genvar k = 1; k < NP; k++) begin : g_node
        if (2 * k >= NP) begin : g_leaf
            localparam int L0 = 2 * k - NP;
            always_ff @(posedge i_clk) begin
                r_hit[k] <= i_match[L0] | i_match[L0+1];
                r_idx[k] <= i_match[L0] ? LV'(L0) : LV'(L0 + 1);
            end
        end else begin : g_inner
            always_ff @(posedge i_clk) begin
                r_hit[k] <= r_hit[2*k] | r_hit[2*k+1];
                r_idx[k] <= r_hit[2*k] ? r_idx[2*k] : r_idx[2*k+1];
            end
        end
    end

    assign o_hit = r_hit[1];
    assign o_idx = r_idx[1];

endmodule
`default_nettype wire

FILE: design/positional_array_list_core.sv
// Positional array list: insert, erase and find over a row of DEPTH cells.
// Insert, erase and bad ops: result registered from the accepted beat; one
// beat per cycle while the result side keeps taking. Find: the result comes
// through the cell match registers and the registered priority tree; no new
// beat is taken meanwhile. Synchronous active-low reset clears the count,
// the control state and the output valid; entries are not.
`default_nettype none
module positional_array_list_core #(
    parameter int DEPTH = pal_pkg::DEFAULT_DEPTH
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_tvalid,
    output logic                            o_s_tready,
    // op [1:0], pos [8:2], value [40:9], zero [47:41]
    input  wire [pal_pkg::S_DATA_W-1:0]     i_s_tdata,
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    // status [1:0], found_index [8:2], count [15:9]
    output logic [pal_pkg::M_DATA_W-1:0]    o_m_tdata
);
    import pal_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LV = $clog2(DEPTH);
    localparam int NP = 1 << LV;
    localparam int EW = (CW > POS_W) ? CW : POS_W;
    localparam int XW = (LV > IDX_W) ? LV : IDX_W;
    localparam int OW = (CW > IDX_W) ? CW : IDX_W;
    localparam int TW = $clog2(LV + 1);

    t_op              w_op;
    logic [POS_W-1:0] w_pos;
    logic [VAL_W-1:0] w_value;
    logic [EW-1:0]    w_pos_x;
    logic [EW-1:0]    w_cnt_x;
    logic             w_acc;
    logic             w_out_free;
    logic             w_full;
    logic             w_ins_ok;
    logic             w_ers_ok;
    logic             w_fnd;
    t_cell_ctl        w_ctl;
    logic [VAL_W-1:0] w_entry [DEPTH];
    logic [NP-1:0]    w_match;
    logic             w_hit;
    logic [LV-1:0]    w_hit_idx;
    logic [XW-1:0]    w_hit_x;
    logic [OW-1:0]    w_cnt_o;

    t_state           r_state;
    t_state           n_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [TW-1:0]    r_wait;
    logic             r_out_valid;
    t_status          r_status;
    logic [IDX_W-1:0] r_found;
    logic [IDX_W-1:0] r_cnt_out;
    logic             w_load;
    t_status          w_status;
    logic [IDX_W-1:0] w_found;

    assign w_op    = t_op'(i_s_tdata[1:0]);
    assign w_pos   = i_s_tdata[8:2];
    assign w_value = i_s_tdata[40:9];
    assign w_pos_x = EW'(w_pos);
    assign w_cnt_x = EW'(r_count);

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_acc      = i_s_tvalid && o_s_tready;

    assign w_full   = (r_count == CW'(DEPTH));
    assign w_ins_ok = w_acc && (w_op == OP_INSERT) && !w_full && (w_pos_x <= w_cnt_x);
    assign w_ers_ok = w_acc && (w_op == OP_ERASE) && (w_pos_x < w_cnt_x);
    assign w_fnd    = w_acc && (w_op == OP_FIND);

    assign w_ctl.ins = w_ins_ok;
    assign w_ctl.ers = w_ers_ok;
    assign w_ctl.fnd = w_fnd;
    assign w_ctl.pos = w_pos;

    always_comb begin
        n_count = r_count;
        if (w_ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_ers_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_entry[g];
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        pal_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_count (r_count),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    for (genvar p = DEPTH; p < NP; p++) begin : g_pad
        assign w_match[p] = 1'b0;
    end

    pal_find_tree #(
        .LV (LV)
    ) u_tree (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_hit   (w_hit),
        .o_idx   (w_hit_idx)
    );

    assign w_hit_x = XW'(w_hit_idx);

    always_comb begin
        n_state  = r_state;
        w_load   = 1'b0;
        w_status = ST_OK;
        w_found  = NONE_INDEX;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (w_op == OP_FIND) begin
                        n_state = S_SEARCH;
                    end else begin
                        w_load = 1'b1;
                        case (w_op)
                            OP_INSERT: begin
                                if (w_full) begin
                                    w_status = ST_FULL;
                                end else if (w_pos_x > w_cnt_x) begin
                                    w_status = ST_BAD;
                                end
                            end
                            OP_ERASE: begin
                                if (w_pos_x >= w_cnt_x) begin
                                    w_status = ST_BAD;
                                end
                            end
                            default: w_status = ST_BAD;
                        endcase
                    end
                end
            end
            S_SEARCH: begin
                if ((r_wait == '0) && w_out_free) begin
                    w_load  = 1'b1;
                    w_found = w_hit ? w_hit_x[IDX_W-1:0] : NONE_INDEX;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_cnt_o = OW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_fnd) begin
                r_wait <= TW'(LV);
            end else if (r_wait != '0) begin
                r_wait <= r_wait - TW'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status  <= w_status;
            r_found   <= w_found;
            r_cnt_out <= w_cnt_o[IDX_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_cnt_out, r_found, r_status};

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_ok |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    a_erase_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ers_ok |=> (r_count == $past(r_count) - CW'(1)))
        else $error("erase did not shrink the list");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && w_load && w_hit) |-> (CW'(w_hit_idx) < r_count))
        else $error("find reported an index past the count");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for positional_array_list_core: directed and random insert, erase, find and unknown
// op beats, each result beat checked as a whole against a list model kept in a scoreboard class.
// Depends on pal_pkg and positional_array_list_core.
`timescale 1ns / 100ps
module tb;
    import pal_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BEATS = 260;
    localparam int TAIL_CYCLES = 16;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] found_index;
        logic [IDX_W-1:0] count;
    } t_list_result;

    class list_result_board;
        logic [VAL_W-1:0] held_vals [DEPTH];
        int               held;
        t_list_result     pending_results [$];
        int               errors;

        function new();
            held = 0;
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Apply one accepted input beat to the list and queue its result.
        function void note_beat(logic [S_DATA_W-1:0] beat);
            logic [OP_W-1:0]  op;
            logic [POS_W-1:0] pos;
            logic [VAL_W-1:0] value;
            t_list_result     res;
            int               i;
            op    = beat[1:0];
            pos   = beat[8:2];
            value = beat[40:9];
            res.status      = ST_OK;
            res.found_index = NONE_INDEX;
            case (op)
                OP_INSERT: begin
                    if (held >= DEPTH) begin
                        res.status = ST_FULL;
                    end else if (int'(pos) > held) begin
                        res.status = ST_BAD;
                    end else begin
                        for (i = held; i > int'(pos); i--) held_vals[i] = held_vals[i-1];
                        held_vals[pos[$clog2(DEPTH)-1:0]] = value;
                        held++;
                    end
                end
                OP_ERASE: begin
                    if (int'(pos) >= held) begin
                        res.status = ST_BAD;
                    end else begin
                        for (i = int'(pos); i + 1 < held; i++) held_vals[i] = held_vals[i+1];
                        held--;
                    end
                end
                OP_FIND: begin
                    for (i = held - 1; i >= 0; i--)
                        if (held_vals[i] == value) res.found_index = IDX_W'(i);
                end
                default: begin
                    res.status = ST_BAD;
                end
            endcase
            res.count = IDX_W'(held);
            pending_results.push_back(res);
        endfunction

        function void check_beat(logic [M_DATA_W-1:0] beat);
            t_list_result got;
            t_list_result want;
            got.status      = beat[1:0];
            got.found_index = beat[8:2];
            got.count       = beat[15:9];
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected: status %0d index %0d count %0d",
                         $time, got.status, $signed(got.found_index), got.count);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                errors++;
                $display({"%0t: mismatch: expected status %0d index %0d count %0d, ",
                          "got status %0d index %0d count %0d"},
                         $time, want.status, $signed(want.found_index), want.count,
                         got.status, $signed(got.found_index), got.count);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tready = 1'b0;
    wire                 o_s_tready;
    wire                 o_m_tvalid;
    wire [M_DATA_W-1:0]  o_m_tdata;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          beats_sent = 0;
    int          cycles = 0;
    list_result_board sb;

    positional_array_list_core #(.DEPTH(DEPTH)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("positional_array_list_core test failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) sb.check_beat(o_m_tdata);
    end

    task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] value);
        logic [S_DATA_W-1:0] beat;
        beat = {7'b0, value, pos, op};
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_beat(beat);
        beats_sent++;
    endtask

    // Hold the input side idle until every queued result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value(input int from_list_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (sb.held > 0 && r < from_list_pct) return sb.held_vals[$urandom_range(sb.held - 1)];
        r = $urandom_range(99);
        if (r < 25) return VAL_W'($urandom_range(7));
        if (r < 35) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_find();
        send_op(OP_FIND, POS_W'($urandom_range(127)), pick_value(60));
    endtask

    task automatic run_fill();
        while (sb.held < DEPTH) begin
            if ($urandom_range(99) < 85)
                send_op(OP_INSERT, POS_W'($urandom_range(sb.held)), pick_value(10));
            else
                send_find();
        end
        repeat (3) send_op(OP_INSERT, POS_W'($urandom_range(127)), pick_value(10));
    endtask

    task automatic run_drain();
        while (sb.held > 0) begin
            if ($urandom_range(99) < 85)
                send_op(OP_ERASE, POS_W'($urandom_range(sb.held - 1)), $urandom);
            else
                send_find();
        end
        repeat (2) send_op(OP_ERASE, POS_W'($urandom_range(127)), $urandom);
    endtask

    task automatic run_mixed();
        int unsigned r;
        logic        fair;
        repeat (30) begin
            r = $urandom_range(99);
            fair = ($urandom_range(99) < 85);
            if (r < 35) begin
                send_op(OP_INSERT, fair ? POS_W'($urandom_range(sb.held))
                                        : POS_W'($urandom_range(127)), pick_value(20));
            end else if (r < 65) begin
                send_op(OP_ERASE, (fair && sb.held > 0) ? POS_W'($urandom_range(sb.held - 1))
                                                        : POS_W'($urandom_range(127)), $urandom);
            end else if (r < 95) begin
                send_find();
            end else begin
                send_op(OP_UNKNOWN, POS_W'($urandom_range(127)), $urandom);
            end
        end
    endtask

    initial begin
        int phase;
        int start;
        int unsigned k;
        sb = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_op(OP_ERASE,  7'd0,   32'h0);
        send_op(OP_FIND,   7'd0,   32'h0);
        send_op(OP_INSERT, 7'd1,   32'h1234_5678);
        send_op(OP_INSERT, 7'd0,   32'h8000_0000);
        send_op(OP_INSERT, 7'd1,   32'h7FFF_FFFF);
        send_op(OP_INSERT, 7'd0,   32'h0);
        send_op(OP_INSERT, 7'd127, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 7'd4,   32'h5);
        send_op(OP_FIND,   7'd127, 32'h7FFF_FFFF);
        send_op(OP_FIND,   7'd0,   32'h8000_0000);
        send_op(OP_FIND,   7'd0,   32'h5);
        send_op(OP_UNKNOWN, 7'd127, 32'hFFFF_FFFF);
        send_op(OP_UNKNOWN, 7'd0,  32'h0);
        send_op(OP_ERASE,  7'd3,   32'h0);
        send_op(OP_ERASE,  7'd127, 32'h0);
        send_op(OP_ERASE,  7'd1,   32'hFFFF_FFFF);
        send_op(OP_INSERT, 7'd2,   32'h0);
        send_op(OP_FIND,   7'd0,   32'h0);
        send_op(OP_ERASE,  7'd0,   32'h0);
        send_op(OP_FIND,   7'd0,   32'h0);
        send_op(OP_ERASE,  7'd2,   32'h0);
        send_op(OP_ERASE,  7'd0,   32'h0);
        send_op(OP_ERASE,  7'd0,   32'h0);
        send_op(OP_FIND,   7'd0,   32'hFFFF_FFFF);
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            start = beats_sent;
            run_fill();
            while (beats_sent - start < PHASE_BEATS) begin
                k = $urandom_range(3);
                if (k == 0) run_fill();
                else if (k == 1) run_drain();
                else run_mixed();
                if ($urandom_range(7) == 0) wait_drained();
            end
            wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("positional_array_list_core test passed");
        end else begin
            $display("positional_array_list_core test failed");
        end
        $finish;
    end
endmodule

FILE: positional_array_list_core.f
design/pal_pkg.sv
design/pal_cell.sv
design/pal_find_tree.sv
design/positional_array_list_core.sv
tb/tb.sv
